// File: rtl/wtqa_pkg.sv
// Package for the weighted two-queue arbiter.
// Holds the command and status codes and the queue control/status structs.
// No dependencies; used by wtqa_queue and the top level in rtl/.
package wtqa_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned TagBitsDefault    = 16;
  localparam int unsigned FuncBits          = 2;
  localparam int unsigned StatusBits        = 3;
  localparam int unsigned BurstBits         = 4;
  localparam logic [BurstBits-1:0] BurstReset = 4'd3;

  typedef enum logic [FuncBits-1:0] {
    FN_PUSH_NORMAL   = 2'd0,
    FN_PUSH_PRIORITY = 2'd1,
    FN_SERVE         = 2'd2
  } func_e;

  typedef enum logic [StatusBits-1:0] {
    ST_QUEUED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_NORMAL   = 3'd2,
    ST_PRIORITY = 3'd3,
    ST_WAIT     = 3'd4
  } status_e;

  // Request from the arbiter to one queue.
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  // Occupancy flags from one queue.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

// File: rtl/wtqa_cell.sv
// One storage cell of a shifting queue: holds a tag, loads a pushed tag
// or takes its upstream neighbour's tag on a pop. Depends on nothing.
module wtqa_cell #(
  parameter int unsigned TagBits = 16
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               shift_i,
  input  logic [TagBits-1:0] push_tag_i,
  input  logic [TagBits-1:0] next_tag_i,
  output logic [TagBits-1:0] tag_o
);

  logic [TagBits-1:0] tag_q, tag_d;

  always_comb begin
    priority if (load_i) begin
      tag_d = push_tag_i;
    end else if (shift_i) begin
      tag_d = next_tag_i;
    end else begin
      tag_d = tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign tag_o = tag_q;

endmodule

// File: rtl/wtqa_queue.sv
// Tag FIFO built as a row of wtqa_cell: head sits in cell 0, a pop shifts
// every cell one place towards the head. Depends on wtqa_pkg, wtqa_cell.
module wtqa_queue #(
  parameter int unsigned QueueDepth = wtqa_pkg::QueueDepthDefault,
  parameter int unsigned TagBits    = wtqa_pkg::TagBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wtqa_pkg::queue_ctrl_t ctrl_i,
  input  logic [TagBits-1:0]    push_tag_i,
  output wtqa_pkg::queue_stat_t stat_o,
  output logic [TagBits-1:0]    head_tag_o
);

  localparam int unsigned CntBits = $clog2(QueueDepth + 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(QueueDepth);

  logic [CntBits-1:0] count_q, count_d;
  logic [TagBits-1:0] chain [QueueDepth+1];
  logic               do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntFull);

  assign do_push = ctrl_i.push & ~stat_o.full;
  assign do_pop  = ctrl_i.pop & ~stat_o.empty;

  // Tail of the row never feeds a live entry; tie it to the push tag.
  assign chain[QueueDepth] = push_tag_i;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    wtqa_cell #(
      .TagBits(TagBits)
    ) u_cell (
      .clk_i     (clk_i),
      .load_i    (do_push && (count_q == CntBits'(i))),
      .shift_i   (do_pop),
      .push_tag_i(push_tag_i),
      .next_tag_i(chain[i+1]),
      .tag_o     (chain[i])
    );
  end

  assign head_tag_o = chain[0];

  always_comb begin
    priority if (do_push) begin
      count_d = count_q + 1'b1;
    end else if (do_pop) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// File: rtl/weighted_two_queue_arbiter.sv
// Weighted two-queue arbiter, top level.
// Instantiates two wtqa_queue rows; takes codes and structs from wtqa_pkg.
//
// Every input beat either pushes a tag into the normal or priority queue
// or asks for one tag to be served, and yields exactly one result beat
// (a beat with func code 3 is taken and dropped with no result). A serve
// hands out priority_burst priority tags in a row, then one normal tag;
// the normal queue is also served whenever the priority queue is empty,
// and status 4 (wait) comes back when both are empty. A push into a full
// queue is dropped with status 1. The queues are rows of cells that shift
// by one place per pop, so a push or pop completes in the cycle the beat
// is accepted and the result lands in an output register. s_axis_tready
// stays high while that register is empty or being drained, so items flow
// one per cycle while m_axis_tready keeps draining results. priority_burst
// is written through the cfg channel (always ready); the user must write it
// only while the block is idle (not enforced by the block); it resets to 3.
module weighted_two_queue_arbiter #(
  parameter int unsigned QueueDepth = wtqa_pkg::QueueDepthDefault,
  parameter int unsigned TagBits    = wtqa_pkg::TagBitsDefault,
  localparam int unsigned InBits    = wtqa_pkg::FuncBits + TagBits,
  localparam int unsigned InBytes   = (InBits + 7) / 8,
  localparam int unsigned OutBits   = wtqa_pkg::StatusBits + TagBits,
  localparam int unsigned OutBytes  = (OutBits + 7) / 8
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Input beats
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] func, [TagBits+1:2] item_tag, zero padding above
  input  logic [InBytes*8-1:0]  s_axis_tdata,

  // Result beats
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] status, [TagBits+2:3] out_tag, zero padding above
  output logic [OutBytes*8-1:0] m_axis_tdata,

  // priority_burst write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wtqa_pkg::BurstBits-1:0]     cfg_data_i
);

  // Unpack the input beat
  wtqa_pkg::func_e     in_func;
  logic [TagBits-1:0]  in_tag;
  logic                in_accept;

  assign in_func   = wtqa_pkg::func_e'(s_axis_tdata[wtqa_pkg::FuncBits-1:0]);
  assign in_tag    = s_axis_tdata[InBits-1:wtqa_pkg::FuncBits];
  assign in_accept = s_axis_tvalid & s_axis_tready;

  // Take a new beat whenever the result register is free or draining
  logic out_valid_q, out_valid_d;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;

  // Burst configuration
  logic [wtqa_pkg::BurstBits-1:0] burst_cfg_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_cfg_q <= wtqa_pkg::BurstReset;
    end else if (cfg_valid_i) begin
      burst_cfg_q <= cfg_data_i;
    end
  end

  // Queues
  wtqa_pkg::queue_ctrl_t n_ctrl, p_ctrl;
  wtqa_pkg::queue_stat_t n_stat, p_stat;
  logic [TagBits-1:0]    n_head, p_head;

  wtqa_queue #(
    .QueueDepth(QueueDepth),
    .TagBits   (TagBits)
  ) u_normal_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (n_ctrl),
    .push_tag_i(in_tag),
    .stat_o    (n_stat),
    .head_tag_o(n_head)
  );

  wtqa_queue #(
    .QueueDepth(QueueDepth),
    .TagBits   (TagBits)
  ) u_priority_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (p_ctrl),
    .push_tag_i(in_tag),
    .stat_o    (p_stat),
    .head_tag_o(p_head)
  );

  // Arbitration
  logic [wtqa_pkg::BurstBits-1:0] burst_q, burst_d;
  logic                           serve_normal;
  wtqa_pkg::status_e              res_status;
  logic [TagBits-1:0]             res_tag;
  logic                           res_valid;

  // Normal wins once the burst is used up, or when nothing is prioritised
  assign serve_normal = ~n_stat.empty & ((burst_q >= burst_cfg_q) | p_stat.empty);

  always_comb begin
    n_ctrl     = '0;
    p_ctrl     = '0;
    burst_d    = burst_q;
    res_status = wtqa_pkg::ST_QUEUED;
    res_tag    = '0;
    res_valid  = 1'b0;
    if (in_accept) begin
      unique case (in_func)
        wtqa_pkg::FN_PUSH_NORMAL: begin
          n_ctrl.push = 1'b1;
          res_valid   = 1'b1;
          res_status  = n_stat.full ? wtqa_pkg::ST_DROPPED : wtqa_pkg::ST_QUEUED;
        end
        wtqa_pkg::FN_PUSH_PRIORITY: begin
          p_ctrl.push = 1'b1;
          res_valid   = 1'b1;
          res_status  = p_stat.full ? wtqa_pkg::ST_DROPPED : wtqa_pkg::ST_QUEUED;
        end
        wtqa_pkg::FN_SERVE: begin
          res_valid = 1'b1;
          priority if (n_stat.empty && p_stat.empty) begin
            res_status = wtqa_pkg::ST_WAIT;
          end else if (serve_normal) begin
            n_ctrl.pop = 1'b1;
            res_status = wtqa_pkg::ST_NORMAL;
            res_tag    = n_head;
            burst_d    = '0;
          end else begin
            p_ctrl.pop = 1'b1;
            res_status = wtqa_pkg::ST_PRIORITY;
            res_tag    = p_head;
            // Saturate at the configured burst
            if (burst_q < burst_cfg_q) begin
              burst_d = burst_q + 1'b1;
            end
          end
        end
        default: begin
          // Unused code: take the beat and drop it
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= '0;
    end else begin
      burst_q <= burst_d;
    end
  end

  // Result register
  wtqa_pkg::status_e  out_status_q;
  logic [TagBits-1:0] out_tag_q;

  always_comb begin
    priority if (in_accept) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      out_status_q <= res_status;
      out_tag_q    <= res_tag;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutBytes*8-OutBits){1'b0}}, out_tag_q, out_status_q};

  // Checks
  property p_wait_when_empty;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_accept && in_func == wtqa_pkg::FN_SERVE && n_stat.empty && p_stat.empty)
      |=> (m_axis_tvalid && out_status_q == wtqa_pkg::ST_WAIT);
  endproperty
  a_wait_when_empty: assert property (p_wait_when_empty)
    else $error("serve on two empty queues did not report wait");

  property p_zero_tag_unless_served;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && (out_status_q == wtqa_pkg::ST_QUEUED ||
                       out_status_q == wtqa_pkg::ST_DROPPED ||
                       out_status_q == wtqa_pkg::ST_WAIT))
      |-> (out_tag_q == '0);
  endproperty
  a_zero_tag_unless_served: assert property (p_zero_tag_unless_served)
    else $error("non-serve result carries a tag");

  property p_normal_clears_burst;
    @(posedge clk_i) disable iff (!rst_ni)
      n_ctrl.pop |=> (burst_q == '0);
  endproperty
  a_normal_clears_burst: assert property (p_normal_clears_burst)
    else $error("burst counter not cleared after normal serve");

  property p_pop_only_nonempty;
    @(posedge clk_i) disable iff (!rst_ni)
      (n_ctrl.pop |-> !n_stat.empty) and (p_ctrl.pop |-> !p_stat.empty);
  endproperty
  a_pop_only_nonempty: assert property (p_pop_only_nonempty)
    else $error("pop issued to an empty queue");

endmodule
